// File: design/g6d_pkg.sv
package g6d_pkg;

  localparam int unsigned COUNT_W = 36;

  // Printable range of a graph6 character and the short header limit.
  localparam logic [7:0] CHAR_BIAS = 8'd63;
  localparam logic [7:0] CHAR_MAX  = 8'd126;
  localparam logic [5:0] SMALL_MAX = 6'd62;
  localparam logic [5:0] LONG_MARK = 6'd63;
  localparam int unsigned BITS_PER_CHAR = 6;

  typedef enum logic [1:0] {
    KIND_COUNT   = 2'd0,
    KIND_EDGE    = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HEAD = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    CMD_HDR  = 2'd0,
    CMD_INV  = 2'd1,
    CMD_BODY = 2'd2
  } cmd_op_t;

  typedef enum logic [1:0] {
    GEN_COUNT   = 2'd0,
    GEN_DONE    = 2'd1,
    GEN_INVALID = 2'd2,
    GEN_BITS    = 2'd3
  } gen_t;

  // One classified character handed from the front to the back.
  typedef struct packed {
    cmd_op_t              op;
    logic                 cond;
    logic [COUNT_W-1:0]   arg;
  } cmd_t;

  typedef struct packed {
    kind_t                kind;
    logic [COUNT_W-1:0]   vc;
    logic [COUNT_W-1:0]   lo;
    logic [COUNT_W-1:0]   hi;
  } res_t;

endpackage

// File: design/g6d_if.sv
interface g6d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;

  modport source (output valid, output data_byte, output start_req, input ready);
  modport sink   (input valid, input data_byte, input start_req, output ready);
endinterface

interface g6d_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [35:0] vertex_count;
  logic [35:0] edge_low;
  logic [35:0] edge_high;
  logic        last;

  modport source (output valid, output kind, output vertex_count, output edge_low,
                  output edge_high, output last, input ready);
  modport sink   (input valid, input kind, input vertex_count, input edge_low,
                  input edge_high, input last, output ready);
endinterface

// File: design/g6d_front.sv
module g6d_front (
  input  logic            clk,
  input  logic            rst,
  g6d_in_if.sink          char_ch,
  output logic            push,
  output g6d_pkg::cmd_t   push_cmd,
  input  logic            full
);

  localparam logic [2:0] HBL_NONE    = 3'd0;
  localparam logic [2:0] HBL_SHORT   = 3'd2;
  localparam logic [2:0] HBL_LONG    = 3'd6;
  localparam logic [2:0] HBL_PENDING = 3'd7;

  g6d_pkg::phase_t phase, phase_next, eff_phase;
  logic [2:0]      hbl, hbl_next, eff_hbl, hbl_dec;
  logic [35:0]     vt, vt_next, eff_vt, vt_shift;
  logic            accept;
  logic            bad;
  logic [7:0]      diff;
  logic [5:0]      v;

  assign char_ch.ready = !full;
  assign accept        = char_ch.valid && !full;

  assign bad      = (char_ch.data_byte < g6d_pkg::CHAR_BIAS) ||
                    (char_ch.data_byte > g6d_pkg::CHAR_MAX);
  assign diff     = char_ch.data_byte - g6d_pkg::CHAR_BIAS;
  assign v        = diff[5:0];
  assign eff_phase = char_ch.start_req ? g6d_pkg::PH_HEAD : phase;
  assign eff_hbl   = char_ch.start_req ? HBL_NONE : hbl;
  assign eff_vt    = char_ch.start_req ? 36'd0 : vt;
  assign vt_shift  = {eff_vt[29:0], v};
  assign hbl_dec   = eff_hbl - 3'd1;

  always_comb begin
    phase_next = phase;
    hbl_next   = hbl;
    vt_next    = vt;
    push       = 1'b0;
    push_cmd   = '{op: g6d_pkg::CMD_BODY, cond: 1'b0, arg: '0};
    if (accept) begin
      if (char_ch.start_req) begin
        phase_next = g6d_pkg::PH_HEAD;
        hbl_next   = HBL_NONE;
        vt_next    = '0;
      end
      case (eff_phase)
        g6d_pkg::PH_HEAD, g6d_pkg::PH_BODY: begin
          if (bad) begin
            push          = 1'b1;
            push_cmd.op   = g6d_pkg::CMD_INV;
            // In the body the back decides whether the graph is still live.
            push_cmd.cond = (eff_phase == g6d_pkg::PH_BODY);
            phase_next    = g6d_pkg::PH_IDLE;
            hbl_next      = HBL_NONE;
          end else if (eff_phase == g6d_pkg::PH_BODY) begin
            push         = 1'b1;
            push_cmd.op  = g6d_pkg::CMD_BODY;
            push_cmd.arg = {30'd0, v};
          end else if (char_ch.start_req) begin
            if (v <= g6d_pkg::SMALL_MAX) begin
              vt_next      = {30'd0, v};
              push         = 1'b1;
              push_cmd.op  = g6d_pkg::CMD_HDR;
              push_cmd.arg = {30'd0, v};
              hbl_next     = HBL_NONE;
              phase_next   = (v[5:1] == 5'd0) ? g6d_pkg::PH_IDLE : g6d_pkg::PH_BODY;
            end else begin
              hbl_next = HBL_PENDING;
            end
          end else if (eff_hbl == HBL_PENDING) begin
            if (v == g6d_pkg::LONG_MARK) begin
              vt_next  = '0;
              hbl_next = HBL_LONG;
            end else begin
              vt_next  = {30'd0, v};
              hbl_next = HBL_SHORT;
            end
          end else begin
            vt_next  = vt_shift;
            hbl_next = hbl_dec;
            if (hbl_dec == HBL_NONE) begin
              push         = 1'b1;
              push_cmd.op  = g6d_pkg::CMD_HDR;
              push_cmd.arg = vt_shift;
              phase_next   = (vt_shift[35:1] == 35'd0) ? g6d_pkg::PH_IDLE
                                                      : g6d_pkg::PH_BODY;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= g6d_pkg::PH_IDLE;
      hbl   <= HBL_NONE;
    end else begin
      phase <= phase_next;
      hbl   <= hbl_next;
    end
  end

  always_ff @(posedge clk) begin
    vt <= vt_next;
  end

endmodule

// File: design/g6d_queue.sv
module g6d_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  g6d_pkg::cmd_t   push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output g6d_pkg::cmd_t   pop_cmd
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  g6d_pkg::cmd_t    mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign pop_valid = (count != '0);
  assign pop_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> pop_valid)
    else $error("queue read while empty");

endmodule

// File: design/g6d_back.sv
module g6d_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  g6d_pkg::cmd_t   q_cmd,
  output logic            q_pop,
  g6d_out_if.source       result_ch
);

  logic                busy, active, cond;
  g6d_pkg::gen_t       gen;
  logic [35:0]         total, row, col;
  logic [5:0]          bits;
  logic [2:0]          left;

  logic                stg_valid, stg_last;
  g6d_pkg::res_t       stg;
  logic                out_valid, out_last;
  g6d_pkg::res_t       out_res;

  logic                would_res, step_end, step_en, gen_res, stg_move, out_free;
  g6d_pkg::res_t       s_res;
  g6d_pkg::gen_t       s_gen;
  logic                s_active;
  logic [35:0]         s_row, s_col, row_inc, col_inc;
  logic [5:0]          s_bits;
  logic [2:0]          s_left;

  assign row_inc = row + 36'd1;
  assign col_inc = col + 36'd1;

  // One step of the generator: at most one result, one adjacency bit.
  always_comb begin
    would_res = 1'b0;
    step_end  = 1'b0;
    s_res     = '{kind: g6d_pkg::KIND_COUNT, vc: '0, lo: '0, hi: '0};
    s_gen     = gen;
    s_active  = active;
    s_row     = row;
    s_col     = col;
    s_bits    = bits;
    s_left    = left;
    case (gen)
      g6d_pkg::GEN_COUNT: begin
        would_res  = 1'b1;
        s_res.kind = g6d_pkg::KIND_COUNT;
        s_res.vc   = total;
        if (total[35:1] == 35'd0) begin
          s_gen = g6d_pkg::GEN_DONE;
        end else begin
          step_end = 1'b1;
        end
      end
      g6d_pkg::GEN_DONE: begin
        would_res  = 1'b1;
        s_res.kind = g6d_pkg::KIND_DONE;
        s_res.vc   = total;
        s_active   = 1'b0;
        step_end   = 1'b1;
      end
      g6d_pkg::GEN_INVALID: begin
        would_res  = !cond || active;
        s_res.kind = g6d_pkg::KIND_INVALID;
        s_active   = 1'b0;
        step_end   = 1'b1;
      end
      g6d_pkg::GEN_BITS: begin
        if (!active) begin
          step_end = 1'b1;
        end else begin
          would_res  = bits[5];
          s_res.kind = g6d_pkg::KIND_EDGE;
          s_res.vc   = total;
          s_res.lo   = row;
          s_res.hi   = col;
          s_bits     = {bits[4:0], 1'b0};
          s_left     = left - 3'd1;
          if (row_inc >= col) begin
            s_row = '0;
            s_col = col_inc;
          end else begin
            s_row = row_inc;
          end
          if ((row_inc >= col) && (col_inc >= total)) begin
            // The last pair: padding bits are dropped and the done beat follows.
            s_gen = g6d_pkg::GEN_DONE;
          end else if (left == 3'd1) begin
            step_end = 1'b1;
          end
        end
      end
      default: begin
        step_end = 1'b1;
      end
    endcase
  end

  assign out_free = !out_valid || result_ch.ready;
  assign step_en  = busy && (!would_res || !stg_valid || out_free);
  assign gen_res  = step_en && would_res;
  assign stg_move = stg_valid && out_free && (stg_last || gen_res);
  assign q_pop    = q_valid && (!busy || (step_en && step_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      active    <= 1'b0;
      gen       <= g6d_pkg::GEN_COUNT;
      stg_valid <= 1'b0;
      stg_last  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy <= 1'b1;
        case (q_cmd.op)
          g6d_pkg::CMD_HDR: begin
            gen    <= g6d_pkg::GEN_COUNT;
            active <= 1'b1;
          end
          g6d_pkg::CMD_INV: begin
            gen <= g6d_pkg::GEN_INVALID;
            if (step_en) active <= s_active;
          end
          g6d_pkg::CMD_BODY: begin
            gen <= g6d_pkg::GEN_BITS;
            if (step_en) active <= s_active;
          end
          default: begin
            gen <= g6d_pkg::GEN_INVALID;
            if (step_en) active <= s_active;
          end
        endcase
      end else if (step_en) begin
        gen    <= s_gen;
        active <= s_active;
        if (step_end) busy <= 1'b0;
      end

      if (gen_res) begin
        stg_valid <= 1'b1;
        stg_last  <= step_end;
      end else if (stg_move) begin
        stg_valid <= 1'b0;
      end else if (step_en && step_end && stg_valid) begin
        // The held beat turns out to be the final one for its character.
        stg_last <= 1'b1;
      end

      if (stg_move) begin
        out_valid <= 1'b1;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cond <= q_cmd.cond;
      case (q_cmd.op)
        g6d_pkg::CMD_HDR: begin
          total <= q_cmd.arg;
          row   <= '0;
          col   <= 36'd1;
        end
        g6d_pkg::CMD_BODY: begin
          bits <= q_cmd.arg[5:0];
          left <= 3'(g6d_pkg::BITS_PER_CHAR);
          if (step_en) begin
            row <= s_row;
            col <= s_col;
          end
        end
        default: begin
          if (step_en) begin
            row  <= s_row;
            col  <= s_col;
            bits <= s_bits;
            left <= s_left;
          end
        end
      endcase
    end else if (step_en) begin
      row  <= s_row;
      col  <= s_col;
      bits <= s_bits;
      left <= s_left;
    end
    if (gen_res) begin
      stg <= s_res;
    end
    if (stg_move) begin
      out_res  <= stg;
      out_last <= stg_last;
    end
  end

  assign result_ch.valid        = out_valid;
  assign result_ch.kind         = out_res.kind;
  assign result_ch.vertex_count = out_res.vc;
  assign result_ch.edge_low     = out_res.lo;
  assign result_ch.edge_high    = out_res.hi;
  assign result_ch.last         = out_last;

  a_open_beat_busy: assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !stg_last) |-> busy)
    else $error("held beat without a character in progress");
  a_bits_left: assert property (@(posedge clk) disable iff (rst)
    (busy && gen == g6d_pkg::GEN_BITS && active) |-> (left != 3'd0))
    else $error("bit step with no bits left");
  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    (result_ch.valid && result_ch.kind == g6d_pkg::KIND_EDGE) |->
    (result_ch.edge_low < result_ch.edge_high &&
     result_ch.edge_high < result_ch.vertex_count))
    else $error("edge endpoints out of order or range");

endmodule

// File: design/graph6_stream_decoder.sv
// Channel    Dir  Beat payload
// char_ch    in   data_byte[7:0], start_req
// result_ch  out  kind[1:0], vertex_count[35:0], edge_low[35:0], edge_high[35:0], last
//
// The front takes one character per cycle while the command queue has room.
// A body character is stepped one adjacency bit at a time in the back; the bit that
// closes the graph ends it early, and the done beat follows.
// A count beat is followed by a done beat below two vertices; an idle back pops first.
// Staging and output registers let the output stall until both are full.
// Synchronous reset clears all control state; there is no clearing pass.
module graph6_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  g6d_in_if.sink     char_ch,
  g6d_out_if.source  result_ch
);

  logic           push, full, pop, pop_valid;
  g6d_pkg::cmd_t  push_cmd, pop_cmd;

  g6d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .char_ch  (char_ch),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full)
  );

  g6d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd)
  );

  g6d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .result_ch (result_ch)
  );

endmodule

// File: sim/graph6_stream_decoder_tb.sv
module graph6_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
  } char_beat_t;

  typedef struct packed {
    g6d_pkg::kind_t              kind;
    logic [g6d_pkg::COUNT_W-1:0] vc;
    logic [g6d_pkg::COUNT_W-1:0] lo;
    logic [g6d_pkg::COUNT_W-1:0] hi;
    logic                        last;
  } result_beat_t;

  logic clk = 1'b0;
  logic rst;

  g6d_in_if  char_if ();
  g6d_out_if res_if ();

  graph6_stream_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .char_ch   (char_if),
    .result_ch (res_if)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  char_beat_t   char_stream [$];
  result_beat_t awaited [$];
  int           stim_items = 0;
  int           mismatches = 0;
  logic         char_fired = 1'b0;

  // Decoder state as the testbench sees it.
  g6d_pkg::phase_t             g6_phase;
  logic [2:0]                  hdr_left;
  logic [g6d_pkg::COUNT_W-1:0] n_vert;
  logic [g6d_pkg::COUNT_W-1:0] col_j;
  logic [g6d_pkg::COUNT_W-1:0] row_i;

  task automatic report_mismatch(input string msg);
    $display("%0t MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic result_beat_t make_beat(input g6d_pkg::kind_t k,
                                             input logic [g6d_pkg::COUNT_W-1:0] vc,
                                             input logic [g6d_pkg::COUNT_W-1:0] lo,
                                             input logic [g6d_pkg::COUNT_W-1:0] hi);
    result_beat_t r;
    r.kind = k;
    r.vc   = vc;
    r.lo   = lo;
    r.hi   = hi;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic decode_char(input logic [7:0] b, input logic st);
    result_beat_t outs [8];
    int           cnt;
    logic [5:0]   bits;
    logic         hdr_complete;
    cnt = 0;
    hdr_complete = 1'b0;
    if (st) begin
      g6_phase = g6d_pkg::PH_HEAD;
      hdr_left = '0;
      n_vert   = '0;
      col_j    = '0;
      row_i    = '0;
    end
    if (g6_phase == g6d_pkg::PH_HEAD || g6_phase == g6d_pkg::PH_BODY) begin
      if (b < g6d_pkg::CHAR_BIAS || b > g6d_pkg::CHAR_MAX) begin
        outs[cnt] = make_beat(g6d_pkg::KIND_INVALID, '0, '0, '0);
        cnt++;
        g6_phase = g6d_pkg::PH_IDLE;
        hdr_left = '0;
      end else begin
        bits = 6'(b - g6d_pkg::CHAR_BIAS);
        if (g6_phase == g6d_pkg::PH_HEAD) begin
          if (st) begin
            if (bits <= g6d_pkg::SMALL_MAX) begin
              n_vert = g6d_pkg::COUNT_W'(bits);
              hdr_complete = 1'b1;
            end else begin
              hdr_left = 3'd7;
            end
          end else if (hdr_left == 3'd7) begin
            // Second header character decides between the 18- and 36-bit forms.
            if (bits > g6d_pkg::SMALL_MAX) begin
              n_vert = '0;
              hdr_left = 3'd6;
            end else begin
              n_vert = g6d_pkg::COUNT_W'(bits);
              hdr_left = 3'd2;
            end
          end else begin
            n_vert = {n_vert[g6d_pkg::COUNT_W-7:0], bits};
            hdr_left = hdr_left - 3'd1;
            if (hdr_left == 3'd0) hdr_complete = 1'b1;
          end
          if (hdr_complete) begin
            outs[cnt] = make_beat(g6d_pkg::KIND_COUNT, n_vert, '0, '0);
            cnt++;
            hdr_left = '0;
            if (n_vert < g6d_pkg::COUNT_W'(2)) begin
              outs[cnt] = make_beat(g6d_pkg::KIND_DONE, n_vert, '0, '0);
              cnt++;
              g6_phase = g6d_pkg::PH_IDLE;
            end else begin
              col_j = g6d_pkg::COUNT_W'(1);
              row_i = '0;
              g6_phase = g6d_pkg::PH_BODY;
            end
          end
        end else begin
          for (int k = 0; k < g6d_pkg::BITS_PER_CHAR && g6_phase == g6d_pkg::PH_BODY;
               k++) begin
            if (bits[5]) begin
              outs[cnt] = make_beat(g6d_pkg::KIND_EDGE, n_vert, row_i, col_j);
              cnt++;
            end
            bits = bits << 1;
            row_i = row_i + 1'b1;
            if (row_i >= col_j) begin
              row_i = '0;
              col_j = col_j + 1'b1;
              if (col_j >= n_vert) begin
                outs[cnt] = make_beat(g6d_pkg::KIND_DONE, n_vert, '0, '0);
                cnt++;
                g6_phase = g6d_pkg::PH_IDLE;
              end
            end
          end
        end
      end
    end
    if (cnt > 0) outs[cnt-1].last = 1'b1;
    for (int i = 0; i < cnt; i++) awaited.push_back(outs[i]);
  endtask

  task automatic add_char(input logic [7:0] b, input logic st, input bit counted = 1'b1);
    char_beat_t c;
    c.b  = b;
    c.st = st;
    char_stream.push_back(c);
    if (counted) stim_items++;
  endtask

  function automatic int pick_vertices();
    if ($urandom_range(0, 9) == 0) return $urandom_range(13, 20);
    return $urandom_range(0, 12);
  endfunction

  // One graph in a random header form; a broken one may be cut short in the body and
  // sometimes ends with a character outside the printable range.
  task automatic add_graph(input int n, input bit broken);
    logic [g6d_pkg::COUNT_W-1:0] nv;
    int                          nbytes;
    int                          limit;
    int                          form;
    logic [5:0]                  density;
    nv = g6d_pkg::COUNT_W'(n);
    nbytes = (n * (n - 1) / 2 + 5) / 6;
    limit = broken ? $urandom_range(0, nbytes) : nbytes;
    form = $urandom_range(0, 9);
    density = ($urandom_range(0, 3) == 0) ? 6'h3f : 6'($urandom_range(0, 63));
    if (form < 7) begin
      add_char(g6d_pkg::CHAR_BIAS + 8'(n), 1'b1);
    end else if (form < 9) begin
      add_char(g6d_pkg::CHAR_MAX, 1'b1);
      for (int s = 2; s >= 0; s--) add_char(g6d_pkg::CHAR_BIAS + 8'(nv[s*6 +: 6]), 1'b0);
    end else begin
      add_char(g6d_pkg::CHAR_MAX, 1'b1);
      add_char(g6d_pkg::CHAR_MAX, 1'b0);
      for (int s = 5; s >= 0; s--) add_char(g6d_pkg::CHAR_BIAS + 8'(nv[s*6 +: 6]), 1'b0);
    end
    for (int i = 0; i < limit; i++)
      add_char(g6d_pkg::CHAR_BIAS + 8'(6'($urandom_range(0, 63)) & density), 1'b0);
    if (broken && $urandom_range(0, 1) == 1) begin
      if ($urandom_range(0, 1) == 1) add_char(8'($urandom_range(0, 62)), 1'b0);
      else add_char(8'($urandom_range(127, 255)), 1'b0);
    end
  endtask

  // Sender: bursts of beats separated by idle gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin
    char_beat_t nxt;
    if (rst) begin
      char_if.valid     <= 1'b0;
      char_if.data_byte <= '0;
      char_if.start_req <= 1'b0;
    end else if (!char_if.valid || char_fired) begin
      if (gap_left > 0 || char_stream.size() == 0) begin
        char_if.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        nxt = char_stream.pop_front();
        char_if.valid     <= 1'b1;
        char_if.data_byte <= nxt.b;
        char_if.start_req <= nxt.st;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Receiver: ready follows a random stall pattern that is redrawn periodically.
  int         stall_tick = 0;
  logic [7:0] stall_pattern = 8'hff;

  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (stall_tick == 0)
        stall_pattern = ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
      res_if.ready <= stall_pattern[3'(stall_tick % 8)];
      stall_tick = (stall_tick + 1) % 24;
    end
  end

  always @(posedge clk) begin
    result_beat_t want;
    if (rst) begin
      char_fired <= 1'b0;
      g6_phase = g6d_pkg::PH_IDLE;
      hdr_left = '0;
      n_vert   = '0;
      col_j    = '0;
      row_i    = '0;
    end else begin
      char_fired <= char_if.valid && char_if.ready;
      if (char_if.valid && char_if.ready) decode_char(char_if.data_byte, char_if.start_req);
      if (res_if.valid && res_if.ready) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat kind %0d", res_if.kind));
        end else begin
          want = awaited.pop_front();
          if (res_if.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", res_if.kind, want.kind));
          if (res_if.vertex_count !== want.vc)
            report_mismatch($sformatf("vertex_count %0d, want %0d",
                                      res_if.vertex_count, want.vc));
          if (res_if.edge_low !== want.lo)
            report_mismatch($sformatf("edge_low %0d, want %0d", res_if.edge_low, want.lo));
          if (res_if.edge_high !== want.hi)
            report_mismatch($sformatf("edge_high %0d, want %0d", res_if.edge_high, want.hi));
          if (res_if.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", res_if.last, want.last));
        end
      end
    end
  end

  initial begin
    int pick;
    rst = 1'b1;

    // Byte while idle is ignored; graphs with zero and one vertex.
    add_char(8'd70, 1'b0);
    add_char(g6d_pkg::CHAR_BIAS, 1'b1);
    add_char(g6d_pkg::CHAR_BIAS + 8'd1, 1'b1);
    // Four vertices, all six pairs set in one beat, then a trailing byte.
    add_char(g6d_pkg::CHAR_BIAS + 8'd4, 1'b1);
    add_char(g6d_pkg::CHAR_MAX, 1'b0);
    add_char(8'd100, 1'b0);
    // Two vertices: one pair, the remaining set bits are padding.
    add_char(g6d_pkg::CHAR_BIAS + 8'd2, 1'b1);
    add_char(g6d_pkg::CHAR_MAX, 1'b0);
    // Five vertices in the 18-bit form, body spans two beats.
    add_char(g6d_pkg::CHAR_MAX, 1'b1);
    add_char(g6d_pkg::CHAR_BIAS, 1'b0);
    add_char(g6d_pkg::CHAR_BIAS, 1'b0);
    add_char(g6d_pkg::CHAR_BIAS + 8'd5, 1'b0);
    add_char(g6d_pkg::CHAR_MAX, 1'b0);
    add_char(g6d_pkg::CHAR_MAX, 1'b0);
    // Largest 36-bit count, one full body beat, then dropped by a new start.
    add_char(g6d_pkg::CHAR_MAX, 1'b1);
    repeat (7) add_char(g6d_pkg::CHAR_MAX, 1'b0);
    add_char(g6d_pkg::CHAR_MAX, 1'b0);
    // Invalid character as the first byte, and one inside a body.
    add_char(8'd0, 1'b1);
    add_char(g6d_pkg::CHAR_BIAS + 8'd62, 1'b1);
    add_char(8'd255, 1'b0);

    while (stim_items < 270) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        add_graph(pick_vertices(), 1'b0);
        if ($urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, 3)) add_char(8'($urandom), 1'b0, 1'b0);
      end else if (pick < 75) begin
        add_char(g6d_pkg::CHAR_MAX, 1'b1);
        if ($urandom_range(0, 1) == 1) begin
          add_char(g6d_pkg::CHAR_BIAS + 8'($urandom_range(0, 62)), 1'b0);
          repeat (2) add_char(g6d_pkg::CHAR_BIAS + 8'($urandom_range(0, 63)), 1'b0);
        end else begin
          add_char(g6d_pkg::CHAR_MAX, 1'b0);
          repeat (6) add_char(g6d_pkg::CHAR_BIAS + 8'($urandom_range(0, 63)), 1'b0);
        end
        repeat ($urandom_range(0, 3))
          add_char(g6d_pkg::CHAR_BIAS + 8'($urandom_range(0, 63)), 1'b0);
      end else if (pick < 90) begin
        add_graph(pick_vertices(), 1'b1);
      end else begin
        repeat ($urandom_range(1, 5))
          add_char(8'($urandom), ($urandom_range(0, 3) == 0));
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (char_stream.size() != 0 || char_if.valid) @(posedge clk);
    while (awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (awaited.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited.size()));

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #1000000;
    report_mismatch("run did not finish in time");
    $display("== FAIL ==");
    $finish;
  end

endmodule
